### rtl/core/glre_pkg.sv
// ----------------------------------------------------------------------------
// glre_pkg: shared types and constants for the gated linear ramp envelope
// Field widths, the rate reset value and the divider status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package glre_pkg;

  localparam int LVL_W         = 24;   // level and envelope, signed Q1.23
  localparam int TIME_W        = 16;   // attack and release time, 1/16 ms
  localparam int RATE_W        = 16;   // samples per ms, Q8.8
  localparam int N_W           = 21;   // ramp length and step counter
  localparam int PROD_W        = TIME_W + RATE_W;
  localparam int RND_SHIFT     = 12;   // 1/16 ms times Q8.8 -> samples
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(12288);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### rtl/core/glre_len.sv
// ----------------------------------------------------------------------------
// glre_len: ramp length
// Rounds time x samples_per_ms to a whole number of samples, half up.
// ----------------------------------------------------------------------------
`default_nettype none

module glre_len
  import glre_pkg::*;
(
  input  wire logic [TIME_W-1:0] time_val,
  input  wire logic [RATE_W-1:0] rate,
  output logic      [N_W-1:0]    len
);

  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]   rnd;

  assign prod = PROD_W'(time_val) * PROD_W'(rate);
  assign rnd  = {1'b0, prod} + (PROD_W + 1)'(1 << (RND_SHIFT - 1));
  assign len  = rnd[PROD_W:RND_SHIFT];

endmodule

`default_nettype wire

### rtl/core/glre_div.sv
// ----------------------------------------------------------------------------
// glre_div: serial unsigned divider
// Restoring division, one quotient bit per cycle with one shared subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module glre_div
  import glre_pkg::*;
#(
  parameter int DW = LVL_W + FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [N_W-1:0] divisor,
  output logic      [DW-1:0] quot,
  output div_stat_t          stat
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [N_W-1:0] rem_r;

  logic [N_W:0]  rem_sh;
  logic [N_W:0]  rem_sub;
  logic          fits;

  // shift in the next dividend bit, then trial subtract
  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign fits    = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], fits};
      rem_r <= fits ? rem_sub[N_W-1:0] : rem_sh[N_W-1:0];
    end
  end

  assign quot      = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

### rtl/core/gated_linear_ramp_envelope.sv
// ----------------------------------------------------------------------------
// gated_linear_ramp_envelope: linear attack/release envelope
// Gate from a nonzero level, linear ramp toward the target per sample.
// ----------------------------------------------------------------------------
// One sample is taken at a time and the input stalls until its result is
// in the output register. A sample with no gate change passes LEN and OUT. A
// gate change that starts a ramp of two or more samples computes the step
// with a serial divider in the DIV state, one quotient bit per cycle, and
// adds it in FIN. A finished result waits in the output register if the
// result channel stalls; the next sample is then held only until the
// register frees. The rate register may be written at any idle moment.
`default_nettype none

module gated_linear_ramp_envelope
  import glre_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [RATE_W-1:0]        cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [LVL_W-1:0]  in_level,
  input  wire logic [TIME_W-1:0]        in_attack_time,
  input  wire logic [TIME_W-1:0]        in_release_time,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [LVL_W-1:0]       out_envelope
);

  localparam int W = LVL_W + FRAC_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LEN  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]              state_r;
  logic [RATE_W-1:0]       rate_r;
  logic signed [LVL_W-1:0] lvl_r;
  logic [TIME_W-1:0]       atk_r;
  logic [TIME_W-1:0]       rel_r;
  logic signed [W-1:0]     cur_r;
  logic signed [W-1:0]     step_r;
  logic signed [LVL_W-1:0] tgt_r;
  logic [N_W-1:0]          left_r;
  logic                    gate_r;
  logic                    neg_r;
  logic signed [LVL_W-1:0] res_r;
  logic signed [LVL_W-1:0] out_r;
  logic                    out_valid_r;

  logic                    in_xfer;
  logic                    gate_now;
  logic [TIME_W-1:0]       time_sel;
  logic [N_W-1:0]          ramp_n;
  logic signed [W-1:0]     lvl_fx;
  logic signed [W-1:0]     tgt_fx;
  logic signed [W:0]       diff;
  logic [W:0]              mag_full;
  logic signed [W-1:0]     cur_sum;
  logic                    div_start;
  logic [W-1:0]            quot;
  div_stat_t               div_stat;
  logic                    out_load;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  assign gate_now = (lvl_r != '0);
  assign time_sel = gate_now ? atk_r : rel_r;
  assign lvl_fx   = {lvl_r, {FRAC_BITS{1'b0}}};
  assign tgt_fx   = {tgt_r, {FRAC_BITS{1'b0}}};
  assign diff     = {lvl_fx[W-1], lvl_fx} - {cur_r[W-1], cur_r};
  // magnitude stays below 2^W, so the top bit is always clear
  assign mag_full = diff[W] ? (W + 1)'(-diff) : (W + 1)'(diff);
  assign cur_sum  = cur_r + step_r;

  assign div_start = (state_r == ST_LEN) && (gate_now != gate_r) &&
                     (ramp_n > N_W'(1));

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  glre_len u_len (
    .time_val (time_sel),
    .rate     (rate_r),
    .len      (ramp_n)
  );

  glre_div #(
    .DW (W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_full[W-1:0]),
    .divisor  (ramp_n),
    .quot     (quot),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RST;
    end else if (cfg_we) begin
      rate_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lvl_r <= in_level;
      atk_r <= in_attack_time;
      rel_r <= in_release_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cur_r   <= '0;
      step_r  <= '0;
      tgt_r   <= '0;
      left_r  <= '0;
      gate_r  <= 1'b0;
      neg_r   <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            state_r <= ST_LEN;
          end
        end
        ST_LEN: begin
          if (gate_now != gate_r) begin
            tgt_r  <= lvl_r;
            gate_r <= gate_now;
            if (ramp_n > N_W'(1)) begin
              neg_r   <= diff[W];
              left_r  <= ramp_n;
              state_r <= ST_DIV;
            end else begin
              step_r  <= '0;
              left_r  <= '0;
              cur_r   <= lvl_fx;
              res_r   <= lvl_r;
              state_r <= ST_OUT;
            end
          end else if (left_r != '0) begin
            res_r  <= cur_sum[W-1:FRAC_BITS];
            left_r <= left_r - N_W'(1);
            // one step left: snap onto the exact target
            if (left_r == N_W'(2)) begin
              step_r <= '0;
              cur_r  <= tgt_fx;
            end else begin
              cur_r <= cur_sum;
            end
            state_r <= ST_OUT;
          end else begin
            res_r   <= tgt_r;
            state_r <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            step_r  <= neg_r ? -$signed(quot) : $signed(quot);
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          cur_r   <= cur_sum;
          res_r   <= cur_sum[W-1:FRAC_BITS];
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // output register, freed by a result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_envelope = out_r;

endmodule

`default_nettype wire

### tb/sv/gated_linear_ramp_envelope_tb.sv
// ----------------------------------------------------------------------------
// gated_linear_ramp_envelope_tb: self-checking bench for the ramp envelope
// Drives gate on/off bursts with random times under several sample rates,
// predicts every envelope sample and checks the result stream in order.
// ----------------------------------------------------------------------------
`default_nettype none

module gated_linear_ramp_envelope_tb;
  import glre_pkg::*;

  localparam int FB            = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 64;   // longer than a divider pass
  localparam int LONG_HOLD     = 400;
  localparam logic signed [LVL_W-1:0] LVL_MAX = 24'sh7FFFFF;
  localparam logic signed [LVL_W-1:0] LVL_MIN = 24'sh800000;

  class envelope_scoreboard;
    logic [RATE_W-1:0]       rate_q8;
    longint                  level_acc;     // Q1.23 with FB extra fraction bits
    longint                  ramp_step;
    logic signed [LVL_W-1:0] target_level;
    int unsigned             ramp_left;
    bit                      gate_on;
    logic signed [LVL_W-1:0] expected_envelopes[$];
    int unsigned             mismatches;

    function new();
      rate_q8      = RATE_RST;
      level_acc    = 0;
      ramp_step    = 0;
      target_level = '0;
      ramp_left    = 0;
      gate_on      = 1'b0;
      mismatches   = 0;
    endfunction

    function void take_sample(logic signed [LVL_W-1:0] lvl, logic [TIME_W-1:0] atk,
                              logic [TIME_W-1:0] rel);
      bit                      gate_now;
      longint unsigned         span;
      longint                  diff;
      longint                  mag;
      longint                  quot;
      logic signed [LVL_W-1:0] env;
      gate_now = (lvl != 0);
      if (gate_now != gate_on) begin
        // ramp length in samples, rounded half up
        span = ((longint'(gate_now ? atk : rel) * longint'(rate_q8)) + 2048) >> RND_SHIFT;
        target_level = lvl;
        gate_on      = gate_now;
        if (span > 1) begin
          diff      = (longint'(target_level) <<< FB) - level_acc;
          mag       = (diff < 0) ? -diff : diff;
          quot      = mag / longint'(span);
          ramp_step = (diff < 0) ? -quot : quot;
          ramp_left = 32'(span);
          level_acc = level_acc + ramp_step;
        end else begin
          ramp_step = 0;
          ramp_left = 0;
          level_acc = longint'(target_level) <<< FB;
        end
        env = LVL_W'(level_acc >>> FB);
      end else if (ramp_left > 0) begin
        level_acc = level_acc + ramp_step;
        env       = LVL_W'(level_acc >>> FB);
        ramp_left--;
        // one step to go: land exactly on the target
        if (ramp_left == 1) begin
          ramp_step = 0;
          level_acc = longint'(target_level) <<< FB;
        end
      end else begin
        env = target_level;
      end
      expected_envelopes.push_back(env);
    endfunction

    function void check_envelope(logic signed [LVL_W-1:0] got);
      logic signed [LVL_W-1:0] want;
      if (expected_envelopes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("envelope transfer with none pending: got %0d", got);
        return;
      end
      want = expected_envelopes.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("envelope mismatch: expected %0d (%h), got %0d (%h)", want, want, got, got);
      end
    endfunction

    function int unsigned pending();
      return expected_envelopes.size();
    endfunction
  endclass

  logic                     clk             = 1'b0;
  logic                     rst_n           = 1'b0;
  logic                     cfg_we          = 1'b0;
  logic [RATE_W-1:0]        cfg_wdata       = '0;
  logic                     in_valid        = 1'b0;
  logic                     in_stall;
  logic signed [LVL_W-1:0]  in_level        = '0;
  logic [TIME_W-1:0]        in_attack_time  = '0;
  logic [TIME_W-1:0]        in_release_time = '0;
  logic                     out_valid;
  logic                     out_stall       = 1'b0;
  logic signed [LVL_W-1:0]  out_envelope;

  envelope_scoreboard sb = new();
  bit                 idle_on   = 1'b1;
  int unsigned        long_hold = 0;

  gated_linear_ramp_envelope #(
    .FRAC_BITS(FB)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_level       (in_level),
    .in_attack_time (in_attack_time),
    .in_release_time(in_release_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_envelope   (out_envelope)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: random stall before each transfer while idle_on is set, one long hold on request
  initial begin : result_side
    int unsigned wait_n;
    forever begin
      if (long_hold != 0) begin
        wait_n    = long_hold;
        long_hold = 0;
      end else begin
        wait_n = idle_on ? $urandom_range(0, 6) : 0;
      end
      if (wait_n != 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_envelope(out_envelope);
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // valid stays high after a transfer so back-to-back samples need no gap
  task automatic send_sample(input logic signed [LVL_W-1:0] lvl,
                             input logic [TIME_W-1:0] atk, input logic [TIME_W-1:0] rel);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_level        <= lvl;
    in_attack_time  <= atk;
    in_release_time <= rel;
    do @(posedge clk); while (in_stall);
    sb.take_sample(lvl, atk, rel);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    sb.rate_q8  = value;
  endtask

  // mostly short times so ramps finish, some full-range ones
  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return TIME_W'($urandom_range(0, 3));
    if (roll < 8) return TIME_W'($urandom_range(0, 40));
    if (roll == 8) return '1;
    return TIME_W'($urandom);
  endfunction

  function automatic logic signed [LVL_W-1:0] pick_level();
    logic signed [LVL_W-1:0] lvl;
    case ($urandom_range(0, 7))
      0: lvl = LVL_MAX;
      1: lvl = LVL_MIN;
      2: lvl = ($urandom_range(0, 1) != 0) ? 24'sd1 : -24'sd1;
      default: lvl = LVL_W'($urandom);
    endcase
    if (lvl == 0) lvl = 24'sd1;
    return lvl;
  endfunction

  // alternating gate-on and gate-off bursts, with some noise items mixed in
  task automatic random_run(input int unsigned count);
    int unsigned             sent;
    int unsigned             burst;
    int unsigned             roll;
    bit                      gate_want;
    logic signed [LVL_W-1:0] open_level;
    logic signed [LVL_W-1:0] lvl;
    sent      = 0;
    gate_want = 1'b0;
    while (sent < count) begin
      if ($urandom_range(0, 7) == 0) idle_on = !idle_on;
      gate_want  = !gate_want;
      burst      = $urandom_range(1, 20);
      open_level = pick_level();
      repeat (burst) begin
        roll = $urandom_range(0, 19);
        if (roll == 0) lvl = LVL_W'($urandom);
        else if (!gate_want) lvl = '0;
        else if (roll < 4) lvl = pick_level();
        else lvl = open_level;
        send_sample(lvl, pick_time(), pick_time());
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [RATE_W-1:0] rates[6];
    rates = '{16'd0, 16'hFFFF, 16'd256, 16'd1, 16'd0, RATE_RST};
    rates[4] = RATE_W'($urandom);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset rate, where a time t gives a 3t-sample ramp
    send_sample('0, 16'd5, 16'd5);          // gate closed, output holds zero
    send_sample(LVL_MAX, 16'd0, 16'd0);     // open with zero attack: jump
    send_sample(-24'sd5, 16'd0, 16'd0);     // level change while open is ignored
    send_sample('0, 16'd0, 16'd1);          // close, three-sample release
    repeat (3) send_sample('0, 16'd0, 16'd0);
    send_sample(LVL_MIN, 16'd2, 16'd0);     // six-sample attack to most negative
    repeat (5) send_sample(24'sd1, 16'd0, 16'd0);
    send_sample('0, 16'hFFFF, 16'd0);       // close with zero release: jump
    send_sample(24'sd1, 16'hFFFF, 16'd0);   // longest attack, step rounds to zero
    send_sample('0, 16'd0, 16'hFFFF);       // longest release from mid-ramp
    send_sample(-24'sd1, 16'd1, 16'd0);
    repeat (3) send_sample(-24'sd1, 16'd0, 16'd0);
    send_sample(LVL_MAX, 16'd0, 16'hFFFF);
    send_sample('0, 16'hFFFF, 16'd0);

    random_run(300);
    foreach (rates[i]) begin
      drain_and_settle();
      write_rate(rates[i]);
      // fill the block up against a stalled result side
      if (i == 1) long_hold = LONG_HOLD;
      random_run(240);
    end
    drain_and_settle();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
